[rtl/iee_pkg.sv]
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

    localparam logic [2:0] OP_HASH = 3'd0;
    localparam logic [2:0] OP_LPAR = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;
    localparam logic [2:0] OP_RPAR = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;
        logic push_number;
        logic pop_operator;
        logic push_operator;
        logic start_reduce;
        logic raise_error;
        logic finish;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_digit;
        logic       is_known;
        logic       number_pending;
        logic       open;
        logic [2:0] code;
        logic [2:0] rank;
        logic [2:0] top;
        logic [2:0] top_rank;
        logic       reduce_done;
    } t_status;

    function automatic logic [2:0] f_stacked_rank(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            OP_HASH: r = 3'd0;
            OP_LPAR: r = 3'd1;
            OP_ADD, OP_SUB: r = 3'd2;
            default: r = 3'd3;
        endcase
        return r;
    endfunction

endpackage

[rtl/iee_divider.sv]
// Iterative 32-bit signed divider, one quotient bit per cycle.
module iee_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_div;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy;
    logic [32:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_div};
        n_rem = w_trial[32] ? {r_rem[30:0], r_quo[31]} : w_trial[31:0];
        n_quo = {r_quo[30:0], ~w_trial[32]};
        n_cnt = r_cnt + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_div  <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg  <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= n_cnt;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done     = r_busy && (r_cnt == 6'd31);
    assign o_quotient = r_neg ? (32'd0 - n_quo) : n_quo;
endmodule

[rtl/iee_datapath.sv]
// Datapath: operand and operator stacks, number builder and arithmetic.
module iee_datapath #(
    parameter int OPERAND_DEPTH  = 16,
    parameter int OPERATOR_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char,
    input  iee_pkg::t_cmd     i_cmd,
    output iee_pkg::t_status  o_status,
    output logic [31:0]       o_value,
    output logic [1:0]        o_result_status
);
    localparam int DW = $clog2(OPERAND_DEPTH);
    localparam int OW = $clog2(OPERATOR_DEPTH);
    localparam int DCW = $clog2(OPERAND_DEPTH + 1);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

    logic [31:0] r_opnd [OPERAND_DEPTH];
    logic [2:0]  r_oper [OPERATOR_DEPTH];
    logic [DCW-1:0] r_dcnt;
    logic [OCW-1:0] r_ocnt;
    logic [31:0] r_acc;
    logic        r_pend;
    logic [1:0]  r_err;
    logic [7:0]  r_char;
    logic [31:0] r_bottom;
    logic [2:0]  r_top;
    logic [31:0] r_out_value;
    logic [1:0]  r_out_status;

    // Reduction sequencing.
    typedef enum logic [3:0] {
        R_IDLE = 4'b0001, R_POP = 4'b0010, R_CALC = 4'b0100, R_DIV = 4'b1000
    } t_rstate;
    t_rstate r_rs;
    logic [2:0]  r_rop;
    logic [31:0] r_lhs, r_rhs;
    logic        r_rdone;
    logic        w_dstart, w_ddone;
    logic [31:0] w_quo;

    logic [2:0] w_code, w_rank, w_top;
    logic       w_known, w_digit;
    logic [1:0] w_new_err;
    logic [DCW-1:0] w_dcnt_after;
    logic [OCW-1:0] w_ocnt_next;

    iee_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(r_lhs), .i_divisor(r_rhs),
        .o_done(w_ddone), .o_quotient(w_quo)
    );

    always_comb begin
        w_known = 1'b1;
        w_code  = iee_pkg::OP_HASH;
        w_rank  = 3'd0;
        unique case (r_char)
            iee_pkg::CH_HASH: begin w_code = iee_pkg::OP_HASH; w_rank = 3'd0; end
            iee_pkg::CH_LPAR: begin w_code = iee_pkg::OP_LPAR; w_rank = 3'd5; end
            iee_pkg::CH_RPAR: begin w_code = iee_pkg::OP_RPAR; w_rank = 3'd1; end
            iee_pkg::CH_ADD:  begin w_code = iee_pkg::OP_ADD;  w_rank = 3'd2; end
            iee_pkg::CH_SUB:  begin w_code = iee_pkg::OP_SUB;  w_rank = 3'd2; end
            iee_pkg::CH_MUL:  begin w_code = iee_pkg::OP_MUL;  w_rank = 3'd3; end
            iee_pkg::CH_DIV:  begin w_code = iee_pkg::OP_DIV;  w_rank = 3'd3; end
            default: w_known = 1'b0;
        endcase
        w_digit = (r_char >= iee_pkg::CH_ZERO) && (r_char <= iee_pkg::CH_NINE);
        w_top = r_top;
    end

    always_comb begin
        w_ocnt_next = r_ocnt;
        if (i_cmd.push_operator && r_ocnt < OCW'(OPERATOR_DEPTH)) begin
            w_ocnt_next = r_ocnt + 1'b1;
        end else if (i_cmd.pop_operator) begin
            w_ocnt_next = r_ocnt - 1'b1;
        end
    end

    assign w_dstart = (r_rs == R_CALC) && (r_rop == iee_pkg::OP_DIV) && (r_rhs != '0);

    always_comb begin
        o_status.is_digit       = w_digit;
        o_status.is_known       = w_known;
        o_status.number_pending = r_pend;
        o_status.open           = (r_ocnt != '0);
        o_status.code           = w_code;
        o_status.rank           = w_rank;
        o_status.top            = w_top;
        o_status.top_rank       = iee_pkg::f_stacked_rank(w_top);
        o_status.reduce_done    = r_rdone;
    end

    always_comb begin
        w_new_err = r_err;
        if (r_err == iee_pkg::ST_OK && r_dcnt != DCW'(1)) begin
            w_new_err = iee_pkg::ST_ERROR;
        end
        w_dcnt_after = r_dcnt;
    end

    assign o_result_status = r_out_status;
    assign o_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_value  <= '0;
            r_out_status <= iee_pkg::ST_OK;
        end else if (i_cmd.finish) begin
            r_out_value  <= (w_new_err == iee_pkg::ST_OK) ? r_bottom : 32'd0;
            r_out_status <= w_new_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_dcnt  <= '0;
            r_ocnt  <= '0;
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_err   <= iee_pkg::ST_OK;
            r_rs    <= R_IDLE;
            r_rdone <= 1'b0;
            r_top   <= iee_pkg::OP_HASH;
        end else begin
            if (i_cmd.load_char) begin
                r_char <= i_char;
            end
            if (i_cmd.raise_error) begin
                r_err <= iee_pkg::ST_ERROR;
            end
            if (i_cmd.push_number) begin
                if (w_digit) begin
                    r_acc  <= (r_acc << 3) + (r_acc << 1) + 32'(r_char[3:0]);
                    r_pend <= 1'b1;
                end else begin
                    r_acc  <= '0;
                    r_pend <= 1'b0;
                    if (r_dcnt < DCW'(OPERAND_DEPTH)) begin
                        r_opnd[DW'(r_dcnt)] <= r_acc;
                        if (r_dcnt == '0) r_bottom <= r_acc;
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        r_err <= iee_pkg::ST_ERROR;
                    end
                end
            end
            if (i_cmd.pop_operator) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
            if (i_cmd.push_operator) begin
                if (r_ocnt < OCW'(OPERATOR_DEPTH)) begin
                    r_oper[OW'(r_ocnt)] <= w_code;
                    r_ocnt <= r_ocnt + 1'b1;
                end else begin
                    r_err <= iee_pkg::ST_ERROR;
                end
            end
            if (i_cmd.push_operator && r_ocnt < OCW'(OPERATOR_DEPTH)) begin
                r_top <= w_code;
            end else if (w_ocnt_next == '0) begin
                r_top <= iee_pkg::OP_HASH;
            end else begin
                r_top <= r_oper[OW'(w_ocnt_next - 1'b1)];
            end
            unique case (r_rs)
                R_IDLE: begin
                    r_rdone <= 1'b0;
                    if (i_cmd.start_reduce) begin
                        r_rop <= w_top;
                        r_rs  <= R_POP;
                    end
                end
                R_POP: begin
                    r_rdone <= 1'b0;
                    // Pop right then left operand in one step.
                    if (r_dcnt >= DCW'(2)) begin
                        r_rhs  <= r_opnd[DW'(r_dcnt - 1'b1)];
                        r_lhs  <= r_opnd[DW'(r_dcnt - DCW'(2))];
                        r_dcnt <= r_dcnt - DCW'(2);
                    end else if (r_dcnt == DCW'(1)) begin
                        r_rhs  <= r_opnd[0];
                        r_lhs  <= '0;
                        r_dcnt <= '0;
                        r_err  <= iee_pkg::ST_ERROR;
                    end else begin
                        r_rhs <= '0;
                        r_lhs <= '0;
                        r_err <= iee_pkg::ST_ERROR;
                    end
                    r_rs <= R_CALC;
                end
                R_CALC, R_DIV: begin
                    logic [31:0] v;
                    logic        ready;
                    v = '0;
                    ready = 1'b1;
                    unique case (r_rop)
                        iee_pkg::OP_ADD: v = r_lhs + r_rhs;
                        iee_pkg::OP_SUB: v = r_lhs - r_rhs;
                        iee_pkg::OP_MUL: v = r_lhs * r_rhs;
                        default: begin
                            if (r_rs == R_CALC) begin
                                if (r_rhs == '0) begin
                                    v = '0;
                                    if (r_err == iee_pkg::ST_OK) r_err <= iee_pkg::ST_DIV0;
                                end else begin
                                    ready = 1'b0;
                                end
                            end else begin
                                v = w_quo;
                                ready = w_ddone;
                            end
                        end
                    endcase
                    r_rdone <= ready;
                    if (ready) begin
                        if (w_dcnt_after < DCW'(OPERAND_DEPTH)) begin
                            r_opnd[DW'(w_dcnt_after)] <= v;
                            if (w_dcnt_after == '0) r_bottom <= v;
                            r_dcnt <= w_dcnt_after + 1'b1;
                        end else begin
                            r_err <= iee_pkg::ST_ERROR;
                        end
                        r_rs    <= R_IDLE;
                    end else begin
                        r_rs <= R_DIV;
                    end
                end
                default: begin
                    r_rdone <= 1'b0;
                    r_rs    <= R_IDLE;
                end
            endcase
        end
    end
endmodule

[rtl/iee_controller.sv]
// Controller state machine sequencing one character through the datapath.
module iee_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  iee_pkg::t_status i_status,
    output iee_pkg::t_cmd    o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_LOOP   = 6'b000100,
        S_WAIT   = 6'b001000,
        S_EMIT   = 6'b010000,
        S_CLEAR  = 6'b100000
    } t_state;
    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_char = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (!i_status.open) begin
                    if (i_status.is_known && i_status.code == iee_pkg::OP_HASH) begin
                        o_cmd.push_operator = 1'b1;
                    end
                end else if (i_status.is_digit) begin
                    o_cmd.push_number = 1'b1;
                end else if (!i_status.is_known) begin
                    o_cmd.raise_error = 1'b1;
                end else begin
                    o_cmd.push_number = i_status.number_pending;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_status.top_rank < i_status.rank) begin
                    if (i_status.code == iee_pkg::OP_RPAR) o_cmd.raise_error = 1'b1;
                    else o_cmd.push_operator = 1'b1;
                    n_state = S_IDLE;
                end else if (i_status.top_rank == i_status.rank
                             && i_status.top_rank <= 3'd1) begin
                    o_cmd.pop_operator = 1'b1;
                    n_state = (i_status.top == iee_pkg::OP_HASH) ? S_EMIT : S_IDLE;
                end else if (i_status.top == iee_pkg::OP_LPAR) begin
                    o_cmd.pop_operator = 1'b1;
                    o_cmd.raise_error  = 1'b1;
                end else begin
                    o_cmd.start_reduce = 1'b1;
                    o_cmd.pop_operator = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.reduce_done) n_state = S_LOOP;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
endmodule

[rtl/infix_expression_evaluator_top.sv]
// Top level of the two-stack infix expression evaluator.
// One character word is taken per handshake. Digits and ignored characters are
// loaded and decoded; an operator then loops through its reductions of + - or *,
// and of division, which runs in a bit-serial divider one quotient bit a cycle, and
// drops each unclosed parenthesis that it meets. The closing '#' also runs its
// reductions: its result word moves into an output register and the block clears,
// so input goes on while that word waits; a second result holds the block, with
// the input stalled, until the first is taken.
module infix_expression_evaluator_top #(
    parameter int OPERAND_DEPTH  = 16,
    parameter int OPERATOR_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status
);
    iee_pkg::t_cmd    w_cmd;
    iee_pkg::t_status w_status;

    iee_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    iee_datapath #(
        .OPERAND_DEPTH(OPERAND_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_char(i_char_code),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_value(o_result_value), .o_result_status(o_status)
    );

    a_ok_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != iee_pkg::ST_OK |-> o_result_value == 32'd0)
        else $error("nonzero value with error status");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
        && $stable(o_status))
        else $error("result word changed while waiting");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("bad status code");
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the infix expression evaluator.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 16;
    localparam int ITEM_TARGET = 1850;
    localparam int BURST_FROM = 700;
    localparam int BURST_TO = 1100;
    localparam int HOLD_AT = 1200;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_code;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_result_value;
    logic [1:0]  o_status;

    infix_expression_evaluator_top #(
        .OPERAND_DEPTH (DEPTH),
        .OPERATOR_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_value(o_result_value),
        .o_status      (o_status)
    );

    // Evaluator state mirrored in the testbench.
    logic [31:0] val_stack [DEPTH];
    int          val_count;
    logic [2:0]  op_stack [DEPTH];
    int          op_count;
    logic [31:0] number_acc;
    bit          number_open;
    logic [1:0]  err_code;

    t_result     pending_results[$];
    int          errors;
    int          chars_sent;
    int          results_seen;
    int          status_seen[3];
    bit          idle_enable;

    function automatic void clear_state();
        val_count = 0;
        op_count = 0;
        number_acc = '0;
        number_open = 0;
        err_code = iee_pkg::ST_OK;
    endfunction

    function automatic void note_error(input logic [1:0] code);
        if (code > err_code) begin
            err_code = code;
        end
    endfunction

    function automatic void push_value(input logic [31:0] v);
        if (val_count < DEPTH) begin
            val_stack[val_count] = v;
            val_count++;
        end else begin
            note_error(iee_pkg::ST_ERROR);
        end
    endfunction

    function automatic logic [31:0] pop_value();
        if (val_count == 0) begin
            note_error(iee_pkg::ST_ERROR);
            return '0;
        end
        val_count--;
        return val_stack[val_count];
    endfunction

    function automatic logic [2:0] op_rank(input logic [2:0] op);
        case (op)
            iee_pkg::OP_HASH: return 3'd0;
            iee_pkg::OP_LPAR: return 3'd1;
            iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 3'd2;
            default: return 3'd3;
        endcase
    endfunction

    function automatic logic [31:0] trunc_divide(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (mb == 0) begin
            note_error(iee_pkg::ST_DIV0);
            return '0;
        end
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void apply_op(input logic [2:0] op);
        logic [31:0] rhs;
        logic [31:0] lhs;
        logic [31:0] r;
        rhs = pop_value();
        lhs = pop_value();
        case (op)
            iee_pkg::OP_ADD: r = lhs + rhs;
            iee_pkg::OP_SUB: r = lhs - rhs;
            iee_pkg::OP_MUL: r = lhs * rhs;
            default: r = trunc_divide(lhs, rhs);
        endcase
        push_value(r);
    endfunction

    // Advances the evaluator by one character; returns 1 with a result when one completes.
    function automatic bit evaluate_char(input logic [7:0] c, output t_result res);
        logic [2:0] code;
        logic [2:0] rank;
        logic [2:0] top;
        logic [2:0] p;
        res = '0;
        if (op_count == 0) begin
            if (c == iee_pkg::CH_HASH) begin
                op_stack[0] = iee_pkg::OP_HASH;
                op_count = 1;
            end
            return 0;
        end
        if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
            number_acc = number_acc * 10 + 32'(c - iee_pkg::CH_ZERO);
            number_open = 1;
            return 0;
        end
        case (c)
            iee_pkg::CH_HASH: begin code = iee_pkg::OP_HASH; rank = 3'd0; end
            iee_pkg::CH_LPAR: begin code = iee_pkg::OP_LPAR; rank = 3'd5; end
            iee_pkg::CH_RPAR: begin code = iee_pkg::OP_RPAR; rank = 3'd1; end
            iee_pkg::CH_ADD:  begin code = iee_pkg::OP_ADD;  rank = 3'd2; end
            iee_pkg::CH_SUB:  begin code = iee_pkg::OP_SUB;  rank = 3'd2; end
            iee_pkg::CH_MUL:  begin code = iee_pkg::OP_MUL;  rank = 3'd3; end
            iee_pkg::CH_DIV:  begin code = iee_pkg::OP_DIV;  rank = 3'd3; end
            default: begin
                note_error(iee_pkg::ST_ERROR);
                return 0;
            end
        endcase
        if (number_open) begin
            push_value(number_acc);
            number_acc = '0;
            number_open = 0;
        end
        forever begin
            top = op_stack[op_count - 1];
            p = op_rank(top);
            if (p < rank) begin
                if (code == iee_pkg::OP_RPAR) begin
                    note_error(iee_pkg::ST_ERROR);
                end else if (op_count < DEPTH) begin
                    op_stack[op_count] = code;
                    op_count++;
                end else begin
                    note_error(iee_pkg::ST_ERROR);
                end
                return 0;
            end
            op_count--;
            if (p == rank && p <= 1) begin
                if (top == iee_pkg::OP_HASH) begin
                    res.status = err_code;
                    if (res.status == iee_pkg::ST_OK && val_count != 1) begin
                        res.status = iee_pkg::ST_ERROR;
                    end
                    if (res.status == iee_pkg::ST_OK) begin
                        res.value = val_stack[0];
                    end
                    clear_state();
                    return 1;
                end
                return 0;
            end
            if (top == iee_pkg::OP_LPAR) begin
                note_error(iee_pkg::ST_ERROR);
            end else begin
                apply_op(top);
            end
            if (op_count == 0) begin
                return 0;
            end
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    // Sends one character word and records what it is expected to produce.
    task automatic send_char(input logic [7:0] c, input bit has_fixed, input t_result fixed);
        t_result res;
        bit done;
        if (idle_enable) begin
            while ($urandom_range(99) < 10) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        done = evaluate_char(c, res);
        if (done) begin
            if (has_fixed && res != fixed) begin
                $display("%0t: table row mismatch expected %h/%0d actual %h/%0d",
                         $time, fixed.value, fixed.status, res.value, res.status);
                errors++;
            end
            pending_results.push_back(res);
        end
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_string(input string s);
        t_result none;
        none = '0;
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], 1'b0, none);
        end
    endtask

    task automatic send_checked(input string s, input logic [31:0] v, input logic [1:0] st);
        t_result none;
        t_result want;
        none = '0;
        want.value = v;
        want.status = st;
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], k == s.len() - 1, k == s.len() - 1 ? want : none);
        end
    endtask

    function automatic string rand_number();
        int digits;
        string s;
        digits = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 3);
        s = "";
        for (int k = 0; k < digits; k++) begin
            s = {s, string'(8'(iee_pkg::CH_ZERO + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_operator();
        case ($urandom_range(3))
            0: return "+";
            1: return "-";
            2: return "*";
            default: return "/";
        endcase
    endfunction

    function automatic string rand_term(input int nest);
        if (nest < 4 && $urandom_range(4) == 0) begin
            return {"(", rand_expr(nest + 1), ")"};
        end
        return rand_number();
    endfunction

    function automatic string rand_expr(input int nest);
        string s;
        int terms;
        terms = ($urandom_range(15) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 5);
        s = rand_term(nest);
        for (int k = 1; k < terms; k++) begin
            s = {s, rand_operator(), rand_term(nest)};
        end
        return s;
    endfunction

    function automatic string corrupt(input string s);
        int pos;
        byte ch;
        pos = $urandom_range(s.len() - 1);
        case ($urandom_range(3))
            0: ch = 8'($urandom_range(255));
            1: ch = iee_pkg::CH_RPAR;
            2: ch = iee_pkg::CH_LPAR;
            default: ch = 8'($urandom_range(8'h80, 8'hFF));
        endcase
        return {s.substr(0, pos - 1), string'(ch), s.substr(pos, s.len() - 1)};
    endfunction

    typedef struct {
        string       text;
        logic [31:0] value;
        logic [1:0]  status;
        bit          fixed;
    } t_row;

    t_row directed_rows[$] = '{
        '{"#0#", 32'd0, iee_pkg::ST_OK, 1'b1},
        '{"#4294967295#", 32'hFFFF_FFFF, iee_pkg::ST_OK, 1'b1},
        '{"#2147483647+1#", 32'h8000_0000, iee_pkg::ST_OK, 1'b1},
        '{"#7/0#", 32'd0, iee_pkg::ST_DIV0, 1'b1},
        '{"#2147483648/4294967295#", 32'h8000_0000, iee_pkg::ST_OK, 1'b1},
        '{"#0-7/2#", 32'hFFFF_FFFD, iee_pkg::ST_OK, 1'b1},
        '{"#1+2*3-4/2#", 32'd0, iee_pkg::ST_OK, 1'b0},
        '{"#(1+2)*(3-4)#", 32'd0, iee_pkg::ST_OK, 1'b0},
        '{"#8-3-2#", 32'd3, iee_pkg::ST_OK, 1'b1},
        '{"#((5))#", 32'd5, iee_pkg::ST_OK, 1'b1},
        '{"#1)#", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"#(1#", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"#1+#", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"##", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"#1 2#", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"#1/0+(2#", 32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"#1+2+3+4+5+6+7+8+9+10+11+12+13+14+15+16+17#", 32'd0, iee_pkg::ST_OK, 1'b0},
        '{"#1*(2*(3*(4*(5*(6*(7*(8*(9*(1*(2*(3*(4*(5*(6*(7*(8))))))))))))))))#",
          32'd0, iee_pkg::ST_ERROR, 1'b1},
        '{"ab)#3#", 32'd3, iee_pkg::ST_OK, 1'b1}
    };

    initial begin
        t_result none;
        string s;
        none = '0;
        errors = 0;
        chars_sent = 0;
        idle_enable = 1'b0;
        i_in_valid = 1'b0;
        i_char_code = '0;
        i_rst_n = 1'b0;
        clear_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].fixed) begin
                send_checked(directed_rows[r].text, directed_rows[r].value,
                             directed_rows[r].status);
            end else begin
                send_string(directed_rows[r].text);
            end
        end
        // Every byte value but '#' once, inside an open expression.
        send_char(iee_pkg::CH_HASH, 1'b0, none);
        for (int b = 0; b < 256; b++) begin
            if (b != iee_pkg::CH_HASH) begin
                send_char(8'(b), 1'b0, none);
            end
        end
        send_char(iee_pkg::CH_HASH, 1'b0, none);
        while (chars_sent < ITEM_TARGET - 3) begin
            idle_enable = !(chars_sent >= BURST_FROM && chars_sent < BURST_TO);
            s = {"#", rand_expr(0), "#"};
            if ($urandom_range(9) == 0) begin
                s = corrupt(s);
            end
            if ($urandom_range(19) == 0) begin
                s = {rand_number(), ")", s};
            end
            send_string(s);
        end
        send_string("#1#");
        i_in_valid <= 1'b0;
        fork
            begin
                while (pending_results.size() != 0) @(posedge i_clk);
                repeat (400) @(posedge i_clk);
            end
            begin
                repeat (500_000) @(posedge i_clk);
                $display("Drain timeout at %0t", $time);
                errors++;
            end
        join_any
        disable fork;
        if (pending_results.size() != 0) begin
            errors++;
        end
        $display("Sent %0d characters, checked %0d results (ok %0d, div0 %0d, error %0d).",
                 chars_sent, results_seen, status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver with random stalls and one long hold-off while the sender keeps going.
    initial begin
        int wait_cycles;
        bit held;
        i_out_ready = 1'b0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && chars_sent >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                wait_cycles = 0;
                while (wait_cycles < 3000) begin
                    @(negedge i_clk);
                    wait_cycles++;
                end
            end else if (idle_enable) begin
                i_out_ready <= ($urandom_range(99) >= 10);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h/%0d",
                         $time, o_result_value, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status <= iee_pkg::ST_ERROR) begin
                    status_seen[o_status]++;
                end
                if (o_result_value != want.value) begin
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, want.value, o_result_value);
                    errors++;
                end
                if (o_status != want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

endmodule
